[hdl/pscz_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscz_pkg
// Types, codes and constants for the point self-crop / transform / z-band
// pipeline.
// ----------------------------------------------------------------------------
package pscz_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic [1:0]         status_t;
  typedef logic [2:0]         cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [31:0]        intensity_bits;
    logic               is_finite;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [31:0]        intensity_out;
  } out_item_t;

  // side data carried along the pipe
  typedef struct packed {
    status_t     rej;
    logic [31:0] inten;
  } side_t;

  localparam status_t ST_KEPT       = 2'd0;
  localparam status_t ST_NOT_FINITE = 2'd1;
  localparam status_t ST_IN_BOX     = 2'd2;
  localparam status_t ST_OUT_BAND   = 2'd3;

  localparam cfg_idx_t CFG_TRANS_X = 3'd0;
  localparam cfg_idx_t CFG_TRANS_Y = 3'd1;
  localparam cfg_idx_t CFG_TRANS_Z = 3'd2;
  localparam cfg_idx_t CFG_ROT_W   = 3'd3;
  localparam cfg_idx_t CFG_ROT_X   = 3'd4;
  localparam cfg_idx_t CFG_ROT_Y   = 3'd5;
  localparam cfg_idx_t CFG_ROT_Z   = 3'd6;
  localparam cfg_idx_t CFG_Z_BAND  = 3'd7;

  localparam logic signed [15:0] ROT_W_RST  = 16'sd16384;
  localparam logic [63:0]        Z_BAND_RST = 64'h0003_0000_0000_0CCD;

  localparam int Q28_W = 35;
  localparam int R24_W = 30;

  localparam logic signed [Q28_W-1:0] ONE_Q28 = 35'sd268435456;
  localparam logic signed [Q28_W-1:0] RND_Q24 = 35'sd8;
  localparam logic signed [63:0]      RND_Q16 = 64'sd8388608;
  localparam logic signed [40:0]      SAT_MAX = 41'sd2147483647;
  localparam logic signed [40:0]      SAT_MIN = -41'sd2147483648;

  localparam int BOX_ROWS = 8;

  localparam coord_t BOX_LO [BOX_ROWS][3] = '{
    '{-29491, -28836, -19661},
    '{-14418, -14418,  22938},
    '{-42598, -36045,  68813},
    '{1, 1, 1}, '{1, 1, 1}, '{1, 1, 1}, '{1, 1, 1}, '{1, 1, 1}
  };

  localparam coord_t BOX_HI [BOX_ROWS][3] = '{
    '{29491, 28836,  29491},
    '{14418, 14418,  78643},
    '{42598, 36045, 121242},
    '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}
  };

endpackage

[hdl/pscz_chan_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscz_chan_if
// Valid/ready item channel with a typed payload.
// ----------------------------------------------------------------------------
interface pscz_chan_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/point_self_crop_transform_zband.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_self_crop_transform_zband
// Body-box crop, quaternion rotation plus translation, and world z-band test
// for Q15.16 lidar points.
// ----------------------------------------------------------------------------
// Eight-stage pipeline: one item per clock while the output is taken.
// The whole pipe advances together; when the output register holds an item
// that is not taken, in_s.ready drops in the same cycle. The rotation matrix
// is rebuilt from the quaternion registers inside the pipe (products, sums,
// rounding) as an item enters; translation and the z band are read in the
// last two stages, so config writes belong in gaps with the pipe empty.
// Each 30x32-bit point product is split into a 30x16 and a 30x17 partial
// product.
// ----------------------------------------------------------------------------
module point_self_crop_transform_zband
  import pscz_pkg::*;
#(
  parameter int NUM_BOXES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  pscz_chan_if.sink   in_s,
  pscz_chan_if.source out_m,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_idx,
  input  logic [63:0] cfg_wdata
);

  // config registers
  logic signed [31:0] trans_r [3];
  logic signed [15:0] q_w_r, q_x_r, q_y_r, q_z_r;
  logic [63:0]        z_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_r[0] <= '0;
      trans_r[1] <= '0;
      trans_r[2] <= '0;
      q_w_r      <= ROT_W_RST;
      q_x_r      <= '0;
      q_y_r      <= '0;
      q_z_r      <= '0;
      z_band_r   <= Z_BAND_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TRANS_X: trans_r[0] <= cfg_wdata[31:0];
        CFG_TRANS_Y: trans_r[1] <= cfg_wdata[31:0];
        CFG_TRANS_Z: trans_r[2] <= cfg_wdata[31:0];
        CFG_ROT_W:   q_w_r      <= cfg_wdata[15:0];
        CFG_ROT_X:   q_x_r      <= cfg_wdata[15:0];
        CFG_ROT_Y:   q_y_r      <= cfg_wdata[15:0];
        CFG_ROT_Z:   q_z_r      <= cfg_wdata[15:0];
        CFG_Z_BAND:  z_band_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [8:1] vld_r;
  logic       adv;

  assign adv        = !vld_r[8] || out_m.ready;
  assign in_s.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[7:1], in_s.valid};
    end
  end

  // stage 1: box test, quaternion products
  coord_t             p_in [3];
  logic               in_box;
  side_t              sd1_nxt;
  logic signed [31:0] qq_nxt [9];

  assign p_in[0] = in_s.data.point_x;
  assign p_in[1] = in_s.data.point_y;
  assign p_in[2] = in_s.data.point_z;

  always_comb begin
    logic hit;
    in_box = 1'b0;
    for (int b = 0; b < NUM_BOXES; b++) begin
      hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (p_in[k] < BOX_LO[b][k] || p_in[k] > BOX_HI[b][k]) begin
          hit = 1'b0;
        end
      end
      in_box = in_box | hit;
    end
    if (!in_s.data.is_finite) begin
      sd1_nxt.rej = ST_NOT_FINITE;
    end else if (in_box) begin
      sd1_nxt.rej = ST_IN_BOX;
    end else begin
      sd1_nxt.rej = ST_KEPT;
    end
    sd1_nxt.inten = in_s.data.intensity_bits;
  end

  // xx yy zz xy xz yz xw yw zw
  always_comb begin
    qq_nxt[0] = q_x_r * q_x_r;
    qq_nxt[1] = q_y_r * q_y_r;
    qq_nxt[2] = q_z_r * q_z_r;
    qq_nxt[3] = q_x_r * q_y_r;
    qq_nxt[4] = q_x_r * q_z_r;
    qq_nxt[5] = q_y_r * q_z_r;
    qq_nxt[6] = q_x_r * q_w_r;
    qq_nxt[7] = q_y_r * q_w_r;
    qq_nxt[8] = q_z_r * q_w_r;
  end

  // stage 2: matrix in Q28
  logic signed [Q28_W-1:0] qq_e [9];
  logic signed [Q28_W-1:0] r28_nxt [9];
  logic signed [31:0]      qq_r [9];

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      qq_e[j] = Q28_W'(qq_r[j]);
    end
    r28_nxt[0] = ONE_Q28 - ((qq_e[1] + qq_e[2]) <<< 1);
    r28_nxt[1] = (qq_e[3] - qq_e[8]) <<< 1;
    r28_nxt[2] = (qq_e[4] + qq_e[7]) <<< 1;
    r28_nxt[3] = (qq_e[3] + qq_e[8]) <<< 1;
    r28_nxt[4] = ONE_Q28 - ((qq_e[0] + qq_e[2]) <<< 1);
    r28_nxt[5] = (qq_e[5] - qq_e[6]) <<< 1;
    r28_nxt[6] = (qq_e[4] - qq_e[7]) <<< 1;
    r28_nxt[7] = (qq_e[5] + qq_e[6]) <<< 1;
    r28_nxt[8] = ONE_Q28 - ((qq_e[0] + qq_e[1]) <<< 1);
  end

  // stage 3: round to Q24
  logic signed [Q28_W-1:0] r28_r [9];
  logic signed [R24_W-1:0] r24_nxt [9];

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      r24_nxt[j] = R24_W'((r28_r[j] + RND_Q24) >>> 4);
    end
  end

  // stage 4: partial products, point split in high and low halves
  logic signed [R24_W-1:0] r24_r [9];
  coord_t                  p1_r [3], p2_r [3], p3_r [3];
  logic signed [45:0]      pph_nxt [9];
  logic signed [46:0]      ppl_nxt [9];

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      pph_nxt[j] = r24_r[j] * $signed(p3_r[j % 3][31:16]);
      ppl_nxt[j] = r24_r[j] * $signed({1'b0, p3_r[j % 3][15:0]});
    end
  end

  // stage 5: combine partial products
  logic signed [45:0] pph_r [9];
  logic signed [46:0] ppl_r [9];
  logic signed [61:0] prod_nxt [9];

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      prod_nxt[j] = (62'(pph_r[j]) <<< 16) + 62'(ppl_r[j]);
    end
  end

  // stage 6: row sums with rounding offset
  logic signed [61:0] prod_r [9];
  logic signed [63:0] acc_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i] = 64'(prod_r[3*i]) + 64'(prod_r[3*i+1]) + 64'(prod_r[3*i+2]) + RND_Q16;
    end
  end

  // stage 7: back to Q16, add translation
  logic signed [63:0] acc_r [3];
  logic signed [40:0] sum_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = 41'(acc_r[i] >>> 24) + 41'(trans_r[i]);
    end
  end

  // stage 8: saturate, band test, output register
  logic signed [40:0] sum_r [3];
  coord_t             wsat [3];
  coord_t             z_min, z_max;
  logic               in_band;
  side_t              sd_r [1:7];
  out_item_t          out_nxt, out_r;

  assign z_min = z_band_r[31:0];
  assign z_max = z_band_r[63:32];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sum_r[i] > SAT_MAX) begin
        wsat[i] = 32'sh7FFF_FFFF;
      end else if (sum_r[i] < SAT_MIN) begin
        wsat[i] = 32'sh8000_0000;
      end else begin
        wsat[i] = 32'(sum_r[i]);
      end
    end
    in_band = (wsat[2] >= z_min) && (wsat[2] <= z_max);
    out_nxt.intensity_out = sd_r[7].inten;
    if (sd_r[7].rej != ST_KEPT) begin
      out_nxt.status  = sd_r[7].rej;
      out_nxt.world_x = '0;
      out_nxt.world_y = '0;
      out_nxt.world_z = '0;
    end else begin
      out_nxt.status  = in_band ? ST_KEPT : ST_OUT_BAND;
      out_nxt.world_x = wsat[0];
      out_nxt.world_y = wsat[1];
      out_nxt.world_z = wsat[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r  <= p_in;
      p2_r  <= p1_r;
      p3_r  <= p2_r;
      qq_r  <= qq_nxt;
      r28_r <= r28_nxt;
      r24_r <= r24_nxt;
      pph_r <= pph_nxt;
      ppl_r <= ppl_nxt;
      prod_r <= prod_nxt;
      acc_r <= acc_nxt;
      sum_r <= sum_nxt;
      sd_r[1] <= sd1_nxt;
      for (int s = 2; s <= 7; s++) begin
        sd_r[s] <= sd_r[s-1];
      end
      out_r <= out_nxt;
    end
  end

  assign out_m.valid = vld_r[8];
  assign out_m.data  = out_r;

endmodule

[bench/pscz_point_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscz_point_checker
// Watches the point and result channels and the register port of the
// self-crop / transform / z-band block. It predicts each result from its own
// copy of the pose registers and compares the results in order, field by
// field.
// ----------------------------------------------------------------------------
module pscz_point_checker
  import pscz_pkg::*;
#(
  parameter int NUM_BOXES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_idx,
  input  logic [63:0] cfg_wdata,
  output int          n_errors,
  output int          n_pending,
  output int          n_results,
  output int          n_kept,
  output int          n_nonfinite,
  output int          n_cropped,
  output int          n_outband
);

  // body boxes in Q15.16, meters times 65536 rounded
  localparam longint CROP_LO [3][3] = '{
    '{-29491, -28836, -19661},
    '{-14418, -14418,  22938},
    '{-42598, -36045,  68813}
  };
  localparam longint CROP_HI [3][3] = '{
    '{29491, 28836,  29491},
    '{14418, 14418,  78643},
    '{42598, 36045, 121242}
  };
  localparam logic [63:0] BAND_AT_RESET = {32'd196608, 32'd3277};

  logic signed [31:0] shift_x, shift_y, shift_z;
  logic signed [15:0] q_w, q_x, q_y, q_z;
  logic [63:0]        band;

  out_item_t placed_points_q [$];

  function automatic out_item_t predict_world_point(input in_item_t pt);
    out_item_t res;
    longint    p [3];
    longint    m [3][3];
    longint    t [3];
    longint    wld [3];
    longint    w, x, y, z, one, acc, v, zlo, zhi;
    logic      in_box;
    res.status        = ST_KEPT;
    res.world_x       = '0;
    res.world_y       = '0;
    res.world_z       = '0;
    res.intensity_out = pt.intensity_bits;
    p[0] = pt.point_x;
    p[1] = pt.point_y;
    p[2] = pt.point_z;
    if (!pt.is_finite) begin
      res.status = ST_NOT_FINITE;
      return res;
    end
    in_box = 1'b0;
    for (int b = 0; b < NUM_BOXES && b < 3; b++) begin
      if (p[0] >= CROP_LO[b][0] && p[0] <= CROP_HI[b][0] &&
          p[1] >= CROP_LO[b][1] && p[1] <= CROP_HI[b][1] &&
          p[2] >= CROP_LO[b][2] && p[2] <= CROP_HI[b][2]) begin
        in_box = 1'b1;
      end
    end
    if (in_box) begin
      res.status = ST_IN_BOX;
      return res;
    end
    w   = q_w;
    x   = q_x;
    y   = q_y;
    z   = q_z;
    one = longint'(1) << 28;
    m[0][0] = one - 2 * (y * y + z * z);
    m[0][1] = 2 * (x * y - z * w);
    m[0][2] = 2 * (x * z + y * w);
    m[1][0] = 2 * (x * y + z * w);
    m[1][1] = one - 2 * (x * x + z * z);
    m[1][2] = 2 * (y * z - x * w);
    m[2][0] = 2 * (x * z - y * w);
    m[2][1] = 2 * (y * z + x * w);
    m[2][2] = one - 2 * (x * x + y * y);
    t[0] = shift_x;
    t[1] = shift_y;
    t[2] = shift_z;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        acc += ((m[i][k] + 8) >>> 4) * p[k];
      end
      v = ((acc + (longint'(1) << 23)) >>> 24) + t[i];
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      wld[i] = v;
    end
    res.world_x = 32'(wld[0]);
    res.world_y = 32'(wld[1]);
    res.world_z = 32'(wld[2]);
    zlo = longint'(signed'(band[31:0]));
    zhi = longint'(signed'(band[63:32]));
    res.status = (wld[2] >= zlo && wld[2] <= zhi) ? ST_KEPT : ST_OUT_BAND;
    return res;
  endfunction

  task automatic log_mismatch(input string msg);
    n_errors++;
    $display("%0t MISMATCH result %0d: %s", $realtime, n_results, msg);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      shift_x = '0;
      shift_y = '0;
      shift_z = '0;
      q_w     = 16'sd16384;
      q_x     = '0;
      q_y     = '0;
      q_z     = '0;
      band    = BAND_AT_RESET;
      placed_points_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TRANS_X: shift_x = cfg_wdata[31:0];
          CFG_TRANS_Y: shift_y = cfg_wdata[31:0];
          CFG_TRANS_Z: shift_z = cfg_wdata[31:0];
          CFG_ROT_W:   q_w     = cfg_wdata[15:0];
          CFG_ROT_X:   q_x     = cfg_wdata[15:0];
          CFG_ROT_Y:   q_y     = cfg_wdata[15:0];
          CFG_ROT_Z:   q_z     = cfg_wdata[15:0];
          CFG_Z_BAND:  band    = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (placed_points_q.size() == 0) begin
          log_mismatch("result with no point waiting");
        end else begin
          want = placed_points_q.pop_front();
          if (out_data.status !== want.status)
            log_mismatch($sformatf("status got %0d want %0d",
                                   out_data.status, want.status));
          if (out_data.world_x !== want.world_x)
            log_mismatch($sformatf("world_x got %0d want %0d",
                                   out_data.world_x, want.world_x));
          if (out_data.world_y !== want.world_y)
            log_mismatch($sformatf("world_y got %0d want %0d",
                                   out_data.world_y, want.world_y));
          if (out_data.world_z !== want.world_z)
            log_mismatch($sformatf("world_z got %0d want %0d",
                                   out_data.world_z, want.world_z));
          if (out_data.intensity_out !== want.intensity_out)
            log_mismatch($sformatf("intensity got %h want %h",
                                   out_data.intensity_out, want.intensity_out));
        end
        n_results++;
        case (out_data.status)
          ST_KEPT:       n_kept++;
          ST_NOT_FINITE: n_nonfinite++;
          ST_IN_BOX:     n_cropped++;
          default:       n_outband++;
        endcase
      end
      if (in_valid && in_ready) begin
        placed_points_q.insert(placed_points_q.size(), predict_world_point(in_data));
      end
    end
    n_pending = placed_points_q.size();
  end

endmodule

[bench/point_self_crop_transform_zband_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_self_crop_transform_zband_tb
// Drives lidar points through the self-crop / transform / z-band block under
// a series of poses and z bands: box corners and edges, band edges,
// non-finite points, saturating poses, an inverted band and random points.
// Both channels stall at random; a checker predicts and compares results.
// ----------------------------------------------------------------------------
module point_self_crop_transform_zband_tb;
  import pscz_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int IDLE_PCT     = 22;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int S32_MAX      = 32'h7FFF_FFFF;
  localparam int S32_MIN      = 32'h8000_0000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_idx;
  logic [63:0] cfg_wdata;
  logic        src_idle_on;
  logic        snk_idle_on;
  int          cycle_cnt;
  int          pose_cnt;
  int          n_errors, n_pending, n_results;
  int          n_kept, n_nonfinite, n_cropped, n_outband;

  pscz_chan_if #(.item_t(in_item_t))  in_if ();
  pscz_chan_if #(.item_t(out_item_t)) out_if ();

  point_self_crop_transform_zband #(.NUM_BOXES(3)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if),
    .out_m     (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  pscz_point_checker #(.NUM_BOXES(3)) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_data     (in_if.data),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_data    (out_if.data),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .n_errors    (n_errors),
    .n_pending   (n_pending),
    .n_results   (n_results),
    .n_kept      (n_kept),
    .n_nonfinite (n_nonfinite),
    .n_cropped   (n_cropped),
    .n_outband   (n_outband)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, n_pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_if.ready = snk_idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  function automatic in_item_t mk_point(input int x, input int y, input int z,
                                        input logic [31:0] inten, input logic fin);
    in_item_t pt;
    pt.point_x        = x;
    pt.point_y        = y;
    pt.point_z        = z;
    pt.intensity_bits = inten;
    pt.is_finite      = fin;
    return pt;
  endfunction

  function automatic in_item_t random_point();
    in_item_t pt;
    int       sel, b, lo, hi;
    int       c [3];
    sel = $urandom_range(99);
    if (sel < 12) begin
      pt = mk_point($urandom, $urandom, $urandom, $urandom, 1'b0);
    end else if (sel < 40) begin
      b = $urandom_range(2);
      for (int k = 0; k < 3; k++) begin
        lo = BOX_LO[b][k];
        hi = BOX_HI[b][k];
        case ($urandom_range(3))
          0:       c[k] = lo + int'($urandom_range(2)) - 1;
          1:       c[k] = hi + int'($urandom_range(2)) - 1;
          2:       c[k] = lo + int'($urandom_range(hi - lo));
          default: c[k] = lo - 20000 + int'($urandom_range(hi - lo + 40000));
        endcase
      end
      pt = mk_point(c[0], c[1], c[2], $urandom, 1'b1);
    end else if (sel < 85) begin
      pt = mk_point(int'($urandom_range(1310720)) - 655360,
                    int'($urandom_range(1310720)) - 655360,
                    int'($urandom_range(393216)) - 131072, $urandom, 1'b1);
    end else begin
      pt = mk_point($urandom, $urandom, $urandom, $urandom, 1'b1);
    end
    return pt;
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task automatic push_point(input in_item_t pt);
    while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data  = pt;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    in_if.valid = 1'b0;
    while (n_pending != 0) @(negedge clk);
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) push_point(random_point());
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  task automatic load_pose(input logic [31:0] tx, input logic [31:0] ty,
                           input logic [31:0] tz, input int qw,
                           input int qx, input int qy,
                           input int qz, input logic [31:0] zmin,
                           input logic [31:0] zmax);
    wait_quiet();
    write_reg(CFG_TRANS_X, {32'h0, tx});
    write_reg(CFG_TRANS_Y, {32'h0, ty});
    write_reg(CFG_TRANS_Z, {32'h0, tz});
    write_reg(CFG_ROT_W,   {48'h0, 16'(qw)});
    write_reg(CFG_ROT_X,   {48'h0, 16'(qx)});
    write_reg(CFG_ROT_Y,   {48'h0, 16'(qy)});
    write_reg(CFG_ROT_Z,   {48'h0, 16'(qz)});
    write_reg(CFG_Z_BAND,  {zmax, zmin});
    cfg_we = 1'b0;
    pose_cnt++;
  endtask

  task automatic load_random_pose(input logic [31:0] zmin, input logic [31:0] zmax);
    real a, b, c, d, n;
    a = real'(int'($urandom_range(32768)) - 16384);
    b = real'(int'($urandom_range(32768)) - 16384);
    c = real'(int'($urandom_range(32768)) - 16384);
    d = real'(int'($urandom_range(32768)) - 16384);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) begin
      a = 1.0;
      n = 1.0;
    end
    load_pose(int'($urandom_range(655360)) - 327680,
              int'($urandom_range(655360)) - 327680,
              int'($urandom_range(131072)) - 65536,
              $rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
              $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0), zmin, zmax);
  endtask

  initial begin
    int zlo;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_TRANS_X;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    src_idle_on  = 1'b1;
    snk_idle_on  = 1'b1;
    pose_cnt     = 1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset pose: identity, no translation, band 0.05 m .. 3.0 m
    push_point(mk_point(S32_MAX, S32_MIN, 0, 32'hFFFF_FFFF, 1'b0));
    push_point(mk_point(0, 0, 0, 32'h0, 1'b0));
    push_point(mk_point(29491, 28836, 29491, 32'h1234_5678, 1'b1));
    push_point(mk_point(-29491, -28836, -19661, 32'h8765_4321, 1'b1));
    push_point(mk_point(29492, 0, 0, 32'hA5A5_A5A5, 1'b1));
    push_point(mk_point(0, 0, -19662, 32'h5A5A_5A5A, 1'b1));
    push_point(mk_point(-14418, -14418, 78643, 32'h0000_0001, 1'b1));
    push_point(mk_point(14418, 14418, 22938, 32'h8000_0000, 1'b1));
    push_point(mk_point(42598, 36045, 121242, 32'h7FFF_FFFF, 1'b1));
    push_point(mk_point(-42598, -36045, 68813, 32'hDEAD_BEEF, 1'b1));
    push_point(mk_point(42599, 0, 100000, 32'hCAFE_F00D, 1'b1));
    push_point(mk_point(65536, 0, 3277, 32'h0F0F_0F0F, 1'b1));
    push_point(mk_point(65536, 0, 3276, 32'hF0F0_F0F0, 1'b1));
    push_point(mk_point(0, 65536, 196608, 32'h3333_3333, 1'b1));
    push_point(mk_point(0, 65536, 196609, 32'hCCCC_CCCC, 1'b1));
    push_point(mk_point(S32_MIN, S32_MAX, S32_MAX, 32'hFFFF_FFFF, 1'b1));
    push_point(mk_point(-1, -1, -1, 32'h0, 1'b1));
    push_random(70);

    // 90 deg yaw, offset pose, band -1 m .. 2 m, no stalls on either side
    load_pose(98304, -131072, 32768, 11585, 0, 0, 11585, -65536, 131072);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    push_random(70);
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;

    // extreme translation, non-normalized quaternion, widest band
    load_pose(S32_MAX, S32_MIN, S32_MIN, -16384, 16384, -16384, 16384, S32_MIN, S32_MAX);
    push_point(mk_point(S32_MAX, S32_MAX, S32_MAX, 32'h1111_1111, 1'b1));
    push_point(mk_point(S32_MIN, S32_MIN, S32_MIN, 32'h2222_2222, 1'b1));
    push_point(mk_point(100000, -100000, 0, 32'h4444_4444, 1'b1));
    push_point(mk_point(0, 0, 0, 32'h8888_8888, 1'b1));
    push_random(60);

    // inverted band: nothing may be kept
    load_random_pose(65536, -65536);
    push_random(30);
    wait_quiet();
    push_random(30);

    zlo = int'($urandom_range(131072)) - 65536;
    load_random_pose(zlo, zlo + int'($urandom_range(262144)));
    push_random(70);

    // 180 deg roll, lifted 1 m, reset band
    load_pose(0, 0, 65536, 0, 16384, 0, 0, 3277, 196608);
    push_random(70);

    wait_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d points under %0d poses (identity, yaw, saturating, random)",
             n_results, pose_cnt);
    $display("Status mix: kept %0d, not finite %0d, in body box %0d, outside band %0d",
             n_kept, n_nonfinite, n_cropped, n_outband);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
